### hdl/nfba_pkg.sv
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared types and constants for the next-fit block allocator.
// ----------------------------------------------------------------------------
package nfba_pkg;

  localparam int REGION_BYTES_DEF = 4096;
  localparam int HEADER_BYTES_DEF = 16;

  localparam int REGION_W = 13;
  localparam int FIELD_W  = 12;
  localparam int STATUS_W = 3;

  localparam logic [REGION_W-1:0] REGION_RESET = 13'd4096;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_GRANTED = 3'd0;
  localparam status_t ST_NO_FIT  = 3'd1;
  localparam status_t ST_BAD_REQ = 3'd2;
  localparam status_t ST_FREED   = 3'd3;
  localparam status_t ST_IGNORED = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

endpackage

### hdl/nfba_hdr_ram.sv
// ----------------------------------------------------------------------------
// nfba_hdr_ram
// Header store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nfba_hdr_ram #(
  parameter int AW = 12,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/next_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_block_allocator
// Next-fit allocator that manages a byte region as a chain of headed blocks.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction is taken at a rising edge where start is high and
//   busy is low. req_type selects allocate (alloc_size payload bytes) or free
//   (free_offset is the payload offset of the block to release).
//   Exactly one result follows each request that no region write cuts
//   short: status, payload_offset and granted_size are valid for the
//   single cycle in which done is high. The receiver cannot stall; the
//   result must be captured in that cycle. Every request not rejected at
//   once walks the block headers in the header store one at a time
//   through one shared next-header adder and the store's single read
//   port: an allocate up to the rover and then on from it, a free up to
//   the block and then from the start up to the rover. So the time a
//   request takes grows with the number of blocks in the region. A request
//   rejected at once is answered from the dispatch state. busy stays high
//   until done. A write on region_wr loads region_size, rebuilds the region
//   as one free block and moves the rover to the start in S_INIT, with busy
//   high. Reset (rst, synchronous) does the same with a 4096-byte region.
// ----------------------------------------------------------------------------
module next_fit_block_allocator #(
  parameter int REGION_BYTES = nfba_pkg::REGION_BYTES_DEF,
  parameter int HEADER_BYTES = nfba_pkg::HEADER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           req_type,
  input  logic [nfba_pkg::FIELD_W-1:0]   alloc_size,
  input  logic [nfba_pkg::FIELD_W-1:0]   free_offset,
  input  logic                           region_wr,
  input  logic [nfba_pkg::REGION_W-1:0]  region_size,
  output logic                           done,
  output nfba_pkg::status_t              status,
  output logic [nfba_pkg::FIELD_W-1:0]   payload_offset,
  output logic [nfba_pkg::FIELD_W-1:0]   granted_size
);

  import nfba_pkg::*;

  // Header addresses are below the region end, header values are signed
  // payload sizes. CW is the working width of all address arithmetic.
  localparam int AW = $clog2(REGION_BYTES);
  localparam int DW = AW + 1;
  localparam int CW = (AW + 3 > 15) ? AW + 3 : 15;

  localparam logic signed [CW-1:0] HB   = CW'(HEADER_BYTES);
  localparam logic signed [CW-1:0] RMAX = CW'(REGION_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_DISPATCH, S_RV_RD, S_RV_EV, S_SR_RD, S_SR_EV,
    S_SPLIT_WR, S_FR_RD, S_FR_EV, S_NX_RD, S_NX_EV
  } state_t;

  state_t state;

  logic                  pend;
  logic                  req_free;
  logic [FIELD_W-1:0]    req_n;
  logic [FIELD_W-1:0]    req_off;
  logic [REGION_W-1:0]   region;
  logic [AW-1:0]         rover;
  logic signed [CW-1:0]  a;
  logic [AW-1:0]         start_pt;
  logic                  wrapped;
  logic                  chk_free;
  logic signed [CW-1:0]  addr_t;
  logic [AW-1:0]         prev_a;
  logic [DW-1:0]         prev_h;
  logic                  prev_v;
  logic [AW-1:0]         base_a;
  logic signed [CW-1:0]  base_v;
  logic [AW-1:0]         rem_a;
  logic [DW-1:0]         rem_v;

  // Memory interface.
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DW-1:0]         mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DW-1:0]         mem_rdata;

  nfba_hdr_ram #(.AW(AW), .DW(DW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  logic signed [CW-1:0] end_c;
  logic signed [CW-1:0] rd_v;
  logic signed [CW-1:0] prev_hc;
  logic signed [CW-1:0] rover_c;
  logic signed [CW-1:0] n_c;
  logic signed [CW-1:0] off_c;
  logic signed [CW-1:0] op_a;
  logic signed [CW-1:0] op_v;
  logic signed [CW-1:0] sum;
  logic signed [CW-1:0] t_c;
  logic signed [CW-1:0] pofs;
  logic signed [CW-1:0] merged;
  logic                 fit;
  logic                 whole;
  logic [AW-1:0]        a_ix;

  assign end_c   = ($signed({{(CW-REGION_W){1'b0}}, region}) > RMAX) ? RMAX
                   : $signed({{(CW-REGION_W){1'b0}}, region});
  assign rd_v    = $signed({{(CW-DW){mem_rdata[DW-1]}}, mem_rdata});
  assign prev_hc = $signed({{(CW-DW){prev_h[DW-1]}}, prev_h});
  assign rover_c = $signed({{(CW-AW){1'b0}}, rover});
  assign n_c     = $signed({{(CW-FIELD_W){1'b0}}, req_n});
  assign off_c   = $signed({{(CW-FIELD_W){1'b0}}, req_off});
  assign a_ix    = a[AW-1:0];

  // The shared next-header unit: start + header + |size|. During the
  // successor lookup of a free it runs on the merged block, else on the
  // header just read.
  assign op_a = (state == S_NX_RD) ? $signed({{(CW-AW){1'b0}}, base_a}) : a;
  assign op_v = (state == S_NX_RD) ? base_v : rd_v;
  assign sum  = op_a + HB + ((op_v < 0) ? -op_v : op_v);

  assign t_c    = -rd_v;
  assign fit    = (rd_v < 0) && (n_c <= t_c);
  assign whole  = (n_c + HB) > t_c;
  assign pofs   = a + HB;
  assign merged = base_v + ((rd_v <= 0) ? (rd_v - HB) : '0);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = a_ix;
    mem_wdata = '0;
    mem_raddr = a_ix;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = DW'(HB - end_c);
      end
      S_SR_EV: begin
        mem_we    = fit;
        mem_wdata = whole ? DW'(t_c) : DW'(n_c);
      end
      S_SPLIT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = rem_a;
        mem_wdata = rem_v;
      end
      S_NX_RD: begin
        mem_raddr = sum[AW-1:0];
        mem_we    = (sum >= end_c);
        mem_waddr = base_a;
        mem_wdata = DW'(base_v);
      end
      S_NX_EV: begin
        mem_we    = 1'b1;
        mem_waddr = base_a;
        mem_wdata = DW'(merged);
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      region   <= REGION_RESET;
      rover    <= '0;
      pend     <= 1'b0;
      done     <= 1'b0;
      wrapped  <= 1'b0;
      chk_free <= 1'b0;
      prev_v   <= 1'b0;
      status         <= ST_GRANTED;
      payload_offset <= '0;
      granted_size   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_free <= req_type;
            req_n    <= alloc_size;
            req_off  <= free_offset;
            pend     <= 1'b1;
            state    <= S_DISPATCH;
          end
        end
        S_INIT: begin
          rover <= '0;
          state <= pend ? S_DISPATCH : S_IDLE;
        end
        S_DISPATCH: begin
          pend           <= 1'b0;
          payload_offset <= '0;
          granted_size   <= '0;
          a              <= '0;
          prev_v         <= 1'b0;
          addr_t         <= off_c - HB;
          if (req_free == REQ_ALLOC) begin
            if (end_c < HB || req_n == '0) begin
              status <= ST_BAD_REQ;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              chk_free <= 1'b0;
              state    <= S_RV_RD;
            end
          end else begin
            if (end_c < HB || off_c < HB) begin
              status <= ST_IGNORED;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              state <= S_FR_RD;
            end
          end
        end
        // Check that the rover still sits on a block start.
        S_RV_RD: begin
          if (a >= end_c || a == rover_c) begin
            if (a >= end_c) begin
              rover <= '0;
            end
            if (chk_free) begin
              status <= ST_FREED;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              a        <= (a >= end_c) ? '0 : rover_c;
              start_pt <= (a >= end_c) ? '0 : rover;
              wrapped  <= 1'b0;
              state    <= S_SR_RD;
            end
          end else begin
            state <= S_RV_EV;
          end
        end
        S_RV_EV: begin
          a     <= sum;
          state <= S_RV_RD;
        end
        // Next-fit search, wrapping once to the start.
        S_SR_RD: begin
          if (a >= end_c) begin
            if (!wrapped && start_pt != '0) begin
              wrapped <= 1'b1;
              a       <= '0;
            end else begin
              rover  <= '0;
              status <= ST_NO_FIT;
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          end else begin
            state <= S_SR_EV;
          end
        end
        S_SR_EV: begin
          if (fit) begin
            rover          <= a_ix;
            status         <= ST_GRANTED;
            payload_offset <= pofs[FIELD_W-1:0];
            if (whole) begin
              granted_size <= t_c[FIELD_W-1:0];
              done         <= 1'b1;
              state        <= S_IDLE;
            end else begin
              granted_size <= req_n;
              rem_a        <= AW'(a + n_c + HB);
              rem_v        <= DW'(n_c + HB - t_c);
              state        <= S_SPLIT_WR;
            end
          end else begin
            a     <= sum;
            state <= S_SR_RD;
          end
        end
        S_SPLIT_WR: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        // Walk to the block being freed, tracking its predecessor.
        S_FR_RD: begin
          if (a >= end_c) begin
            status <= ST_IGNORED;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_FR_EV;
          end
        end
        S_FR_EV: begin
          if (a == addr_t) begin
            if (rd_v < 0) begin
              status <= ST_IGNORED;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              if (prev_v && prev_hc <= 0) begin
                base_a <= prev_a;
                base_v <= prev_hc - rd_v - HB;
              end else begin
                base_a <= a_ix;
                base_v <= -rd_v;
              end
              state <= S_NX_RD;
            end
          end else begin
            prev_a <= a_ix;
            prev_h <= mem_rdata;
            prev_v <= 1'b1;
            a      <= sum;
            state  <= S_FR_RD;
          end
        end
        // Successor lookup; the merged header is written here or next cycle.
        S_NX_RD: begin
          if (sum < end_c) begin
            state <= S_NX_EV;
          end else begin
            a        <= '0;
            chk_free <= 1'b1;
            state    <= S_RV_RD;
          end
        end
        S_NX_EV: begin
          a        <= '0;
          chk_free <= 1'b1;
          state    <= S_RV_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (region_wr) begin
        region <= region_size;
        state  <= S_INIT;
      end
    end
  end

endmodule

### hdl/nfba_checker.sv
// ----------------------------------------------------------------------------
// nfba_checker
// Port-level checks for the next-fit block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module nfba_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          region_wr,
  input logic                          done,
  input nfba_pkg::status_t             status,
  input logic [nfba_pkg::FIELD_W-1:0]  payload_offset,
  input logic [nfba_pkg::FIELD_W-1:0]  granted_size
);

  import nfba_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    ((start && !busy) || region_wr) |=> busy)
    else $error("accepted transaction or region write did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a transaction in progress");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("more than one result for a transaction");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_GRANTED || status == ST_NO_FIT || status == ST_BAD_REQ ||
              status == ST_FREED || status == ST_IGNORED))
    else $error("undefined status code");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_GRANTED) |-> (payload_offset == '0 && granted_size == '0))
    else $error("nonzero offset or size on a refused transaction");

endmodule

bind next_fit_block_allocator nfba_checker u_nfba_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .region_wr      (region_wr),
  .done           (done),
  .status         (status),
  .payload_offset (payload_offset),
  .granted_size   (granted_size)
);
